/* rtl/lph_pkg.sv */
// shared types and constants of the linear probing hash table
package lph_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 13;
  localparam int CFG_W   = 13;

  // golden ratio constant 0.6180 in q0.32
  localparam logic [KEY_W-1:0] A_Q32 = 32'd2654289789;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic HASH_DIV = 1'b0;
  localparam logic HASH_MUL = 1'b1;

  localparam logic REG_HASH_MODE  = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] probe_count;
    logic [CNT_W-1:0] match_count;
    logic             table_full;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic start;
    logic mode;
  } hash_ctl_t;

endpackage

/* rtl/lph_hash.sv */
// home slot unit: bit-serial remainder or two passes through one shared multiplier
module lph_hash #(
  parameter int SIZE_W = 13,
  parameter int IDX_W  = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lph_pkg::hash_ctl_t      ctl,
  input  logic [lph_pkg::KEY_W-1:0] key,
  input  logic [SIZE_W-1:0]       size,
  output logic                    done,
  output logic [IDX_W-1:0]        home
);

  localparam int BIT_W = $clog2(lph_pkg::KEY_W);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_DIV  = 2'd1;
  localparam logic [1:0] H_MUL0 = 2'd2;
  localparam logic [1:0] H_MUL1 = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [lph_pkg::KEY_W-1:0] sh_r, sh_nxt;
  logic [lph_pkg::KEY_W-1:0] frac_r, frac_nxt;
  logic [SIZE_W-1:0]         size_r, size_nxt;
  logic [SIZE_W-1:0]         rem_r, rem_nxt;
  logic [BIT_W-1:0]          bit_r, bit_nxt;
  logic [IDX_W-1:0]          home_r, home_nxt;
  logic                      done_r, done_nxt;

  logic [SIZE_W:0]           trial;
  logic [lph_pkg::KEY_W-1:0] mul_a, mul_b;
  logic [2*lph_pkg::KEY_W-1:0] prod;

  assign trial = {rem_r, sh_r[lph_pkg::KEY_W-1]};
  assign mul_a = (state_r == H_MUL0) ? sh_r : frac_r;
  assign mul_b = (state_r == H_MUL0) ? lph_pkg::A_Q32 : lph_pkg::KEY_W'(size_r);
  assign prod  = (2*lph_pkg::KEY_W)'(mul_a) * (2*lph_pkg::KEY_W)'(mul_b);

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    frac_nxt  = frac_r;
    size_nxt  = size_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    home_nxt  = home_r;
    done_nxt  = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (ctl.start) begin
          sh_nxt    = key;
          size_nxt  = size;
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = (ctl.mode == lph_pkg::HASH_MUL) ? H_MUL0 : H_DIV;
        end
      end
      H_DIV: begin
        // restoring remainder, one key bit a cycle
        if (trial >= {1'b0, size_r}) begin
          rem_nxt = SIZE_W'(trial - {1'b0, size_r});
        end else begin
          rem_nxt = trial[SIZE_W-1:0];
        end
        sh_nxt  = {sh_r[lph_pkg::KEY_W-2:0], 1'b0};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BIT_W'(lph_pkg::KEY_W - 1)) begin
          home_nxt  = IDX_W'(rem_nxt);
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_MUL0: begin
        frac_nxt  = prod[lph_pkg::KEY_W-1:0];
        state_nxt = H_MUL1;
      end
      H_MUL1: begin
        home_nxt  = prod[lph_pkg::KEY_W +: IDX_W];
        done_nxt  = 1'b1;
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    sh_r   <= sh_nxt;
    frac_r <= frac_nxt;
    size_r <= size_nxt;
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
    home_r <= home_nxt;
  end

  assign done = done_r;
  assign home = home_r;

endmodule

/* rtl/linear_probe_hash_table_unit.sv */
// linear probing hash table: config registers, slot memory and probe sequencer
//
//   channel | ports                              | transaction
//   --------+------------------------------------+------------------------------
//   request | start, busy, in_data               | start high while busy low
//   result  | out_valid, out_data                | one cycle with out_valid high
//   config  | cfg_we, cfg_index, cfg_data        | cfg_we high
//
// insert/search: hash by bit-serial division or by multiplication, then a read and a check
//   state per probe on the slot memory, then the result in the next cycle
// clear and unknown requests: clear sweeps all TABLE_DEPTH slots, unknown answers without probing
// reset starts a clearing pass over all TABLE_DEPTH slots with busy high
// the result is shown for one cycle and cannot be held off
module linear_probe_hash_table_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  lph_pkg::in_t            in_data,
  output logic                    out_valid,
  output lph_pkg::out_t           out_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [lph_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic                      hash_mode_r;
  logic [lph_pkg::CFG_W-1:0] table_size_r;
  logic [SIZE_W-1:0]         eff_size;

  logic [2:0]                state_r, state_nxt;
  logic [1:0]                req_r, req_nxt;
  logic [lph_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      clr_req_r, clr_req_nxt;
  logic [IDX_W-1:0]          clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  logic [SIZE_W-1:0]         cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]         match_r, match_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lph_pkg::out_t             out_data_r, out_data_nxt;

  lph_pkg::slot_t            mem [TABLE_DEPTH];
  lph_pkg::slot_t            rd_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_wa;
  lph_pkg::slot_t            mem_wd;

  lph_pkg::hash_ctl_t        hash_ctl;
  logic                      hash_done;
  logic [IDX_W-1:0]          hash_home;

  logic                      accept;
  logic [SIZE_W-1:0]         cnt_inc;
  logic [SIZE_W-1:0]         pos_inc;
  logic                      last_probe;

  // size 0 acts as 1, anything past the memory depth as the depth
  always_comb begin
    if (table_size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = SIZE_W'(table_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mode_r  <= lph_pkg::HASH_DIV;
      table_size_r <= lph_pkg::TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lph_pkg::REG_HASH_MODE:  hash_mode_r  <= cfg_data[0];
        lph_pkg::REG_TABLE_SIZE: table_size_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign cnt_inc = cnt_r + 1'b1;
  assign pos_inc = SIZE_W'(pos_r) + 1'b1;
  assign last_probe = (cnt_inc == eff_size);

  assign hash_ctl.start = accept && (in_data.req_type == lph_pkg::REQ_INSERT ||
                                     in_data.req_type == lph_pkg::REQ_SEARCH);
  assign hash_ctl.mode  = hash_mode_r;

  lph_hash #(
    .SIZE_W (SIZE_W),
    .IDX_W  (IDX_W)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (hash_ctl),
    .key   (in_data.key),
    .size  (eff_size),
    .done  (hash_done),
    .home  (hash_home)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    clr_req_nxt   = clr_req_r;
    clr_addr_nxt  = clr_addr_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    match_nxt     = match_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_we        = 1'b0;
    mem_wa        = pos_r;
    mem_wd        = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(TABLE_DEPTH - 1)) begin
          clr_addr_nxt  = '0;
          out_valid_nxt = clr_req_r;
          clr_req_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_data.req_type;
          key_nxt   = in_data.key;
          cnt_nxt   = '0;
          match_nxt = '0;
          case (in_data.req_type)
            lph_pkg::REQ_INSERT,
            lph_pkg::REQ_SEARCH: state_nxt = S_HASH;
            lph_pkg::REQ_CLEAR: begin
              clr_req_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          pos_nxt   = hash_home;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_READ;
        if (pos_inc == eff_size) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = IDX_W'(pos_inc);
        end
        cnt_nxt = cnt_inc;
        if (req_r == lph_pkg::REQ_INSERT) begin
          if (!rd_r.valid) begin
            mem_we                   = 1'b1;
            mem_wd.valid             = 1'b1;
            mem_wd.key               = key_r;
            out_valid_nxt            = 1'b1;
            out_data_nxt.probe_count = lph_pkg::CNT_W'(cnt_r);
            state_nxt                = S_IDLE;
          end else if (last_probe) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.probe_count = lph_pkg::CNT_W'(cnt_inc);
            out_data_nxt.table_full  = 1'b1;
            state_nxt                = S_IDLE;
          end
        end else begin
          if (rd_r.valid && rd_r.key == key_r) begin
            match_nxt = match_r + 1'b1;
          end
          if (!rd_r.valid || last_probe) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.match_count = lph_pkg::CNT_W'(match_nxt);
            state_nxt                = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_req_r   <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_req_r   <= clr_req_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a reset always runs the clearing pass before the first request
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("no clearing pass after reset");

  // an insert or search transaction keeps the block busy while it probes
  a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == lph_pkg::REQ_INSERT ||
                in_data.req_type == lph_pkg::REQ_SEARCH)) |=> busy)
    else $error("probe request did not hold busy");

  // insert results carry no match count, search results no probe count
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.match_count == '0 ||
                   (out_data.probe_count == '0 && !out_data.table_full)))
    else $error("result mixes insert and search fields");

  // a full table is reported only after every slot of the run was probed
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |->
      (32'(out_data.probe_count) == 32'(eff_size)))
    else $error("table full with short probe count");

endmodule
